FILE: sv/sfd_pkg.sv
package sfd_pkg;

  // Parser phase codes
  localparam logic [2:0] PH_SYNC1   = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_COMMAND = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CKS_HI  = 3'd5;
  localparam logic [2:0] PH_CKS_LO  = 3'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 8'd1;

  // Result kinds
  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // One result item
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] command;
    logic [7:0] frame_length;
    logic       checksum_ok;
  } result_t;

endpackage

FILE: sv/sfd_parser.sv
module sfd_parser
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  input  logic [7:0] sync_first,
  input  logic [7:0] sync_second,
  output logic       res_valid,
  output result_t    res
);

  logic [2:0]  phase, phase_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  checksum_high, checksum_high_next;
  logic [15:0] sum_add;
  logic [7:0]  count_inc;

  assign sum_add   = running_sum + {8'd0, rx_byte};
  assign count_inc = payload_count + 8'd1;

  // Parse step for the byte on the input
  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    payload_count_next = payload_count;
    held_command_next  = held_command;
    held_length_next   = held_length;
    checksum_high_next = checksum_high;
    res_valid          = 1'b0;
    res                = '0;
    case (phase)
      PH_SYNC2: begin
        if (rx_byte == sync_second) phase_next = PH_COMMAND;
      end
      PH_COMMAND: begin
        held_command_next = rx_byte;
        running_sum_next  = {8'd0, rx_byte};
        phase_next        = PH_LENGTH;
      end
      PH_LENGTH: begin
        held_length_next = rx_byte;
        running_sum_next = sum_add;
        if (rx_byte != 8'd0) begin
          payload_count_next = 8'd0;
          phase_next         = PH_PAYLOAD;
        end else begin
          phase_next = PH_CKS_HI;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next   = sum_add;
        payload_count_next = count_inc;
        if (count_inc >= held_length) phase_next = PH_CKS_HI;
        res_valid          = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = rx_byte;
      end
      PH_CKS_HI: begin
        checksum_high_next = rx_byte;
        phase_next         = PH_CKS_LO;
      end
      PH_CKS_LO: begin
        phase_next       = PH_SYNC1;
        res_valid        = 1'b1;
        res.kind         = KIND_FRAME_END;
        res.command      = held_command;
        res.frame_length = held_length;
        res.checksum_ok  = (running_sum[7:0] == rx_byte) &&
                           (running_sum[15:8] == checksum_high);
      end
      default: begin
        // waiting for the first sync byte (unused code behaves the same)
        phase_next = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      running_sum   <= '0;
      payload_count <= '0;
      held_command  <= '0;
      held_length   <= '0;
      checksum_high <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      payload_count <= payload_count_next;
      held_command  <= held_command_next;
      held_length   <= held_length_next;
      checksum_high <= checksum_high_next;
    end
  end

  a_res_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (phase == PH_PAYLOAD || phase == PH_CKS_LO))
    else $error("result outside payload or checksum phase");

  a_end_resync: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == PH_CKS_LO) |=> (phase == PH_SYNC1))
    else $error("parser did not return to sync search after frame end");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (payload_count < held_length))
    else $error("payload count overran frame length");

endmodule

FILE: sv/sfd_out_queue.sv
module sfd_out_queue
  import sfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  logic    skid_valid;
  result_t skid;
  logic    pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  // Head register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (skid_valid) begin
        head <= skid;
        if (push) skid <= push_data;
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with empty head");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid))
    else $error("transfer pushed into a full queue");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && pop && !push) |=> !skid_valid)
    else $error("skid stage did not drain");

endmodule

FILE: sv/serial_frame_deframer.sv
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------------
// in      | in_valid / in_ready  | rx_byte
// out     | out_valid / out_ready| kind, payload_byte, command, frame_length,
//         |                      | checksum_ok
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle while in_ready is high; each result is registered in the output queue before it shows on out.
// The parse step sits between the input port and a two-entry output queue.
// in_ready drops only while both queue entries hold results; cfg_ready is
// always high. Synchronous reset clears the parser and empties the queue;
// both sync registers reset to zero.
module serial_frame_deframer
  import sfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 kind,
  output logic [7:0]           payload_byte,
  output logic [7:0]           command,
  output logic [7:0]           frame_length,
  output logic                 checksum_ok,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic       fire;
  logic       res_valid;
  logic       space;
  result_t    res;
  result_t    head;

  assign cfg_ready = 1'b1;
  assign in_ready  = space;
  assign fire      = in_valid && space;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= '0;
      sync_second <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  sfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .rx_byte    (rx_byte),
    .sync_first (sync_first),
    .sync_second(sync_second),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfd_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fire && res_valid),
    .push_data(res),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign kind         = head.kind;
  assign payload_byte = head.payload_byte;
  assign command      = head.command;
  assign frame_length = head.frame_length;
  assign checksum_ok  = head.checksum_ok;

endmodule
